// ===== hw/rtl/particle_contact_resolver_top_assert.svh =====
// Assertion macros shared by the resolver RTL.
`ifndef PARTICLE_CONTACT_RESOLVER_TOP_ASSERT_SVH
`define PARTICLE_CONTACT_RESOLVER_TOP_ASSERT_SVH

// Implication in the same cycle.
`define PCR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("resolver assertion failed");

// Implication in the next cycle.
`define PCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("resolver assertion failed");

`endif

// ===== hw/rtl/pcr_pkg.sv =====
package pcr_pkg;

    localparam int COMP_W        = 21;
    localparam int VEC_W         = 3 * COMP_W;
    localparam int SCAL_W        = 32;
    localparam int RESTITUTION_W = 17;
    localparam int DELTA_TIME_W  = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int DIV_STEPS     = 32;

    localparam logic [RESTITUTION_W-1:0] RESTITUTION_RESET = 17'd52429;
    localparam logic [DELTA_TIME_W-1:0]  DELTA_TIME_RESET  = 16'd1092;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESTITUTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_TIME  = 2'd1;

    typedef struct packed {
        logic [VEC_W-1:0]         velocity_one;
        logic [VEC_W-1:0]         velocity_two;
        logic [VEC_W-1:0]         accel_one;
        logic [VEC_W-1:0]         accel_two;
        logic [VEC_W-1:0]         position_one;
        logic [VEC_W-1:0]         position_two;
        logic [VEC_W-1:0]         contact_normal;
        logic [SCAL_W-1:0]        inv_mass_one;
        logic [SCAL_W-1:0]        inv_mass_two;
        logic signed [SCAL_W-1:0] penetration_depth;
        logic                     has_partner;
    } item_t;

    typedef struct packed {
        logic [VEC_W-1:0] new_velocity_one;
        logic [VEC_W-1:0] new_velocity_two;
        logic [VEC_W-1:0] new_position_one;
        logic [VEC_W-1:0] new_position_two;
        logic [VEC_W-1:0] move_one;
        logic [VEC_W-1:0] move_two;
        logic             impulse_applied;
        logic             moved_apart;
    } result_t;

    // Per-contact data that rides along the whole pipe
    typedef struct packed {
        logic [VEC_W-1:0]  v1;
        logic [VEC_W-1:0]  v2;
        logic [VEC_W-1:0]  p1;
        logic [VEC_W-1:0]  p2;
        logic [VEC_W-1:0]  n;
        logic [SCAL_W-1:0] m1;
        logic [SCAL_W-1:0] m2;
    } carry_t;

    // Front end to divider
    typedef struct packed {
        carry_t            c;
        logic              imp_en;
        logic              mov_en;
        logic              dv_neg;
        logic [SCAL_W-1:0] dv_mag;
        logic [SCAL_W-1:0] pen_mag;
        logic [SCAL_W:0]   im;
    } div_req_t;

    // Divider to back end
    typedef struct packed {
        carry_t            c;
        logic              imp_en;
        logic              mov_en;
        logic              dv_neg;
        logic              ovf_a;
        logic              ovf_b;
        logic [SCAL_W-1:0] q_a;
        logic [SCAL_W-1:0] q_b;
    } div_rsp_t;

    function automatic logic signed [COMP_W-1:0] comp(input logic [VEC_W-1:0] v,
                                                      input int unsigned i);
        return v[COMP_W*i +: COMP_W];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -66'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [COMP_W-1:0] sat21(input logic signed [65:0] x);
        if (x > 66'sd1048575)
            return 21'sh0fffff;
        else if (x < -66'sd1048576)
            return 21'sh100000;
        else
            return x[COMP_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/pcr_front.sv =====
// Scalar front end: separating velocity, target velocity and delta-v.
// Six register stages, one item per cycle unless stalled by req_ready.
module pcr_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_ready,
    input  pcr_pkg::item_t                         item,
    input  logic [pcr_pkg::RESTITUTION_W-1:0]      restitution,
    input  logic [pcr_pkg::DELTA_TIME_W-1:0]       delta_time,
    output logic                                   req_valid,
    input  logic                                   req_ready,
    output pcr_pkg::div_req_t                      req
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic req_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    pcr_pkg::carry_t s1_c_reg, s2_c_reg, s3_c_reg, s4_c_reg, s5_c_reg, s1_c_next;
    logic signed [42:0] s1_rvn_reg [3];
    logic signed [42:0] s1_ran_reg [3];
    logic signed [42:0] s1_rvn_next [3];
    logic signed [42:0] s1_ran_next [3];
    logic signed [31:0] s1_pen_reg, s2_pen_reg, s3_pen_reg, s4_pen_reg, s5_pen_reg;
    logic signed [31:0] s2_sep_reg, s3_sep_reg, s4_sep_reg, s5_sep_reg, s2_sep_next;
    logic signed [44:0] s2_dota_reg, s2_dota_next;
    logic signed [61:0] s3_accm_reg, s3_accm_next;
    logic signed [50:0] s3_tprod_reg, s3_tprod_next;
    logic signed [31:0] s4_acc_reg, s5_acc_reg, s4_acc_next;
    logic signed [34:0] s4_t0_reg, s5_t0_reg, s4_t0_next;
    logic signed [49:0] s5_radd_reg, s5_radd_next;
    pcr_pkg::div_req_t  req_reg, req_next;

    logic signed [17:0] rest_s;
    logic signed [16:0] dt_s;

    assign rest_s = $signed({1'b0, restitution});
    assign dt_s   = $signed({1'b0, delta_time});

    // stall chain
    assign rdy6       = !req_valid_reg || req_ready;
    assign rdy5       = !s5_valid_reg || rdy6;
    assign rdy4       = !s4_valid_reg || rdy5;
    assign rdy3       = !s3_valid_reg || rdy4;
    assign rdy2       = !s2_valid_reg || rdy3;
    assign rdy1       = !s1_valid_reg || rdy2;
    assign item_ready = rdy1;
    assign req_valid  = req_valid_reg;
    assign req        = req_reg;

    // stage 1: relative vectors times normal
    always_comb
    begin
        logic signed [21:0] rv;
        logic signed [21:0] ra;
        logic signed [20:0] v2c;
        logic signed [20:0] a2c;
        s1_c_next.v1 = item.velocity_one;
        s1_c_next.v2 = item.velocity_two;
        s1_c_next.p1 = item.position_one;
        s1_c_next.p2 = item.position_two;
        s1_c_next.n  = item.contact_normal;
        s1_c_next.m1 = item.inv_mass_one;
        s1_c_next.m2 = item.has_partner ? item.inv_mass_two : '0;
        for (int c = 0; c < 3; c++)
        begin
            v2c = item.has_partner ? pcr_pkg::comp(item.velocity_two, c) : 21'sd0;
            a2c = item.has_partner ? pcr_pkg::comp(item.accel_two, c) : 21'sd0;
            rv  = 22'(pcr_pkg::comp(item.velocity_one, c)) - 22'(v2c);
            ra  = 22'(pcr_pkg::comp(item.accel_one, c)) - 22'(a2c);
            s1_rvn_next[c] = 43'(rv) * 43'(pcr_pkg::comp(item.contact_normal, c));
            s1_ran_next[c] = 43'(ra) * 43'(pcr_pkg::comp(item.contact_normal, c));
        end
    end

    // stage 2: dot products, separating velocity
    always_comb
    begin
        logic signed [44:0] sum;
        sum = 45'(s1_rvn_reg[0]) + 45'(s1_rvn_reg[1]) + 45'(s1_rvn_reg[2]);
        s2_sep_next  = pcr_pkg::sat32(66'(sum >>> 4));
        s2_dota_next = 45'(s1_ran_reg[0]) + 45'(s1_ran_reg[1]) + 45'(s1_ran_reg[2]);
    end

    // stage 3: acceleration term and restitution target products
    always_comb
    begin
        logic signed [32:0] neg_sep;
        neg_sep       = -(33'(s2_sep_reg));
        s3_accm_next  = 62'(s2_dota_reg) * 62'(dt_s);
        s3_tprod_next = 51'(neg_sep) * 51'(rest_s);
    end

    // stage 4: scale down
    assign s4_acc_next = pcr_pkg::sat32(66'(s3_accm_reg >>> 20));
    assign s4_t0_next  = 35'(s3_tprod_reg >>> 16);

    // stage 5: restitution times acceleration term
    assign s5_radd_next = 50'(rest_s) * 50'(s4_acc_reg);

    // stage 6: target, delta-v, divider operands
    always_comb
    begin
        logic signed [35:0] t;
        logic signed [31:0] target;
        logic signed [32:0] dv33;
        logic signed [31:0] dv;
        t = 36'(s5_t0_reg);
        if (s5_acc_reg < 0)
        begin
            t = t + 36'(s5_radd_reg >>> 16);
            if (t < 0)
                t = '0;
        end
        target = pcr_pkg::sat32(66'(t));
        dv33   = 33'(target) - 33'(s5_sep_reg);
        dv     = pcr_pkg::sat32(66'(dv33));

        req_next.c       = s5_c_reg;
        req_next.im      = {1'b0, s5_c_reg.m1} + {1'b0, s5_c_reg.m2};
        req_next.imp_en  = (req_next.im != '0) && (s5_sep_reg <= 0);
        req_next.mov_en  = (req_next.im != '0) && (s5_pen_reg > 0);
        req_next.dv_neg  = dv < 0;
        req_next.dv_mag  = (dv < 0) ? 32'(-(33'(dv))) : 32'(dv);
        req_next.pen_mag = (s5_pen_reg > 0) ? 32'(s5_pen_reg) : '0;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            req_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) s1_valid_reg  <= item_valid;
            if (rdy2) s2_valid_reg  <= s1_valid_reg;
            if (rdy3) s3_valid_reg  <= s2_valid_reg;
            if (rdy4) s4_valid_reg  <= s3_valid_reg;
            if (rdy5) s5_valid_reg  <= s4_valid_reg;
            if (rdy6) req_valid_reg <= s5_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (rdy1 && item_valid)
        begin
            s1_c_reg   <= s1_c_next;
            s1_rvn_reg <= s1_rvn_next;
            s1_ran_reg <= s1_ran_next;
            s1_pen_reg <= item.penetration_depth;
        end
        if (rdy2 && s1_valid_reg)
        begin
            s2_c_reg    <= s1_c_reg;
            s2_pen_reg  <= s1_pen_reg;
            s2_sep_reg  <= s2_sep_next;
            s2_dota_reg <= s2_dota_next;
        end
        if (rdy3 && s2_valid_reg)
        begin
            s3_c_reg     <= s2_c_reg;
            s3_pen_reg   <= s2_pen_reg;
            s3_sep_reg   <= s2_sep_reg;
            s3_accm_reg  <= s3_accm_next;
            s3_tprod_reg <= s3_tprod_next;
        end
        if (rdy4 && s3_valid_reg)
        begin
            s4_c_reg   <= s3_c_reg;
            s4_pen_reg <= s3_pen_reg;
            s4_sep_reg <= s3_sep_reg;
            s4_acc_reg <= s4_acc_next;
            s4_t0_reg  <= s4_t0_next;
        end
        if (rdy5 && s4_valid_reg)
        begin
            s5_c_reg    <= s4_c_reg;
            s5_pen_reg  <= s4_pen_reg;
            s5_sep_reg  <= s4_sep_reg;
            s5_acc_reg  <= s4_acc_reg;
            s5_t0_reg   <= s4_t0_reg;
            s5_radd_reg <= s5_radd_next;
        end
        if (rdy6 && s5_valid_reg)
            req_reg <= req_next;
    end

endmodule

// ===== hw/rtl/pcr_div.sv =====
// Dual pipelined restoring divider: delta-v and penetration, both
// scaled by 2^16 and divided by total inverse mass. One quotient bit
// per stage after an overflow-check stage.
module pcr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  pcr_pkg::div_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output pcr_pkg::div_rsp_t rsp
);

    typedef struct packed {
        logic [pcr_pkg::SCAL_W:0]   rem;
        logic [pcr_pkg::SCAL_W-1:0] nb;
        logic [pcr_pkg::SCAL_W-1:0] q;
    } lane_t;

    typedef struct packed {
        pcr_pkg::carry_t          c;
        logic                     imp_en;
        logic                     mov_en;
        logic                     dv_neg;
        logic                     ovf_a;
        logic                     ovf_b;
        logic [pcr_pkg::SCAL_W:0] im;
        lane_t                    a;
        lane_t                    b;
    } stage_t;

    stage_t st_reg  [0:pcr_pkg::DIV_STEPS];
    stage_t st_next [0:pcr_pkg::DIV_STEPS];
    logic   vld_reg [0:pcr_pkg::DIV_STEPS];
    logic   rdy     [0:pcr_pkg::DIV_STEPS];

    // one quotient bit
    function automatic lane_t div_step(input lane_t l, input logic [pcr_pkg::SCAL_W:0] d);
        logic [pcr_pkg::SCAL_W+1:0] r2;
        lane_t o;
        r2 = {l.rem, l.nb[pcr_pkg::SCAL_W-1]};
        if (r2 >= {1'b0, d})
        begin
            o.rem = (pcr_pkg::SCAL_W+1)'(r2 - {1'b0, d});
            o.q   = {l.q[pcr_pkg::SCAL_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = r2[pcr_pkg::SCAL_W:0];
            o.q   = {l.q[pcr_pkg::SCAL_W-2:0], 1'b0};
        end
        o.nb = {l.nb[pcr_pkg::SCAL_W-2:0], 1'b0};
        return o;
    endfunction

    // stall chain
    always_comb
    begin
        rdy[pcr_pkg::DIV_STEPS] = !vld_reg[pcr_pkg::DIV_STEPS] || rsp_ready;
        for (int k = pcr_pkg::DIV_STEPS - 1; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    // entry: high half of the dividend checked against the divisor
    always_comb
    begin
        st_next[0].c      = req.c;
        st_next[0].imp_en = req.imp_en;
        st_next[0].mov_en = req.mov_en;
        st_next[0].dv_neg = req.dv_neg;
        st_next[0].im     = req.im;
        st_next[0].a.rem  = (pcr_pkg::SCAL_W+1)'(req.dv_mag[31:16]);
        st_next[0].a.nb   = {req.dv_mag[15:0], 16'h0000};
        st_next[0].a.q    = '0;
        st_next[0].b.rem  = (pcr_pkg::SCAL_W+1)'(req.pen_mag[31:16]);
        st_next[0].b.nb   = {req.pen_mag[15:0], 16'h0000};
        st_next[0].b.q    = '0;
        st_next[0].ovf_a  = st_next[0].a.rem >= req.im;
        st_next[0].ovf_b  = st_next[0].b.rem >= req.im;
        for (int k = 1; k <= pcr_pkg::DIV_STEPS; k++)
        begin
            st_next[k]   = st_reg[k-1];
            st_next[k].a = div_step(st_reg[k-1].a, st_reg[k-1].im);
            st_next[k].b = div_step(st_reg[k-1].b, st_reg[k-1].im);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= pcr_pkg::DIV_STEPS; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= req_valid;
            for (int k = 1; k <= pcr_pkg::DIV_STEPS; k++)
                if (rdy[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && req_valid)
            st_reg[0] <= st_next[0];
        for (int k = 1; k <= pcr_pkg::DIV_STEPS; k++)
            if (rdy[k] && vld_reg[k-1])
                st_reg[k] <= st_next[k];
    end

    assign req_ready  = rdy[0];
    assign rsp_valid  = vld_reg[pcr_pkg::DIV_STEPS];
    assign rsp.c      = st_reg[pcr_pkg::DIV_STEPS].c;
    assign rsp.imp_en = st_reg[pcr_pkg::DIV_STEPS].imp_en;
    assign rsp.mov_en = st_reg[pcr_pkg::DIV_STEPS].mov_en;
    assign rsp.dv_neg = st_reg[pcr_pkg::DIV_STEPS].dv_neg;
    assign rsp.ovf_a  = st_reg[pcr_pkg::DIV_STEPS].ovf_a;
    assign rsp.ovf_b  = st_reg[pcr_pkg::DIV_STEPS].ovf_b;
    assign rsp.q_a    = st_reg[pcr_pkg::DIV_STEPS].a.q;
    assign rsp.q_b    = st_reg[pcr_pkg::DIV_STEPS].b.q;

endmodule

// ===== hw/rtl/pcr_back.sv =====
`include "particle_contact_resolver_top_assert.svh"

// Back end: impulse and move per unit mass, scaled by each inverse mass,
// applied to velocities and positions. Four register stages, the last
// being the output register.
module pcr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rsp_valid,
    output logic              rsp_ready,
    input  pcr_pkg::div_rsp_t rsp,
    output logic              result_valid,
    input  logic              result_ready,
    output pcr_pkg::result_t  result
);

    logic b0_valid_reg, b1_valid_reg, b2_valid_reg, out_valid_reg;
    logic rdy0, rdy1, rdy2, rdy3;

    pcr_pkg::carry_t b0_c_reg, b1_c_reg, b2_c_reg;
    logic b0_imp_reg, b1_imp_reg, b2_imp_reg;
    logic b0_mov_reg, b1_mov_reg, b2_mov_reg;

    logic signed [52:0] b0_pn_reg [3];
    logic signed [52:0] b0_qn_reg [3];
    logic signed [52:0] b0_pn_next [3];
    logic signed [52:0] b0_qn_next [3];
    logic signed [31:0] b1_ipm_reg [3];
    logic signed [31:0] b1_mpm_reg [3];
    logic signed [31:0] b1_ipm_next [3];
    logic signed [31:0] b1_mpm_next [3];
    logic signed [64:0] b2_pv1_reg [3];
    logic signed [64:0] b2_pv2_reg [3];
    logic signed [64:0] b2_pm1_reg [3];
    logic signed [64:0] b2_pm2_reg [3];
    logic signed [64:0] b2_pv1_next [3];
    logic signed [64:0] b2_pv2_next [3];
    logic signed [64:0] b2_pm1_next [3];
    logic signed [64:0] b2_pm2_next [3];
    pcr_pkg::result_t   out_reg, out_next;

    assign rdy3         = !out_valid_reg || result_ready;
    assign rdy2         = !b2_valid_reg || rdy3;
    assign rdy1         = !b1_valid_reg || rdy2;
    assign rdy0         = !b0_valid_reg || rdy1;
    assign rsp_ready    = rdy0;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // stage 0: saturate quotients, times normal
    always_comb
    begin
        logic signed [31:0] imp;
        logic signed [31:0] qv;
        if (rsp.ovf_a)
            imp = rsp.dv_neg ? 32'sh80000000 : 32'sh7fffffff;
        else if (rsp.dv_neg)
            imp = (rsp.q_a > 32'h80000000) ? 32'sh80000000 : 32'(-(33'({1'b0, rsp.q_a})));
        else
            imp = rsp.q_a[31] ? 32'sh7fffffff : $signed(rsp.q_a);
        qv = (rsp.ovf_b || rsp.q_b[31]) ? 32'sh7fffffff : $signed(rsp.q_b);
        for (int c = 0; c < 3; c++)
        begin
            b0_pn_next[c] = 53'(pcr_pkg::comp(rsp.c.n, c)) * 53'(imp);
            b0_qn_next[c] = 53'(pcr_pkg::comp(rsp.c.n, c)) * 53'(qv);
        end
    end

    // stage 1: per unit inverse mass
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            b1_ipm_next[c] = pcr_pkg::sat32(66'(b0_pn_reg[c] >>> 10));
            b1_mpm_next[c] = pcr_pkg::sat32(66'(b0_qn_reg[c] >>> 10));
        end
    end

    // stage 2: scale by each inverse mass
    always_comb
    begin
        logic signed [32:0] m1s;
        logic signed [32:0] m2s;
        m1s = $signed({1'b0, b1_c_reg.m1});
        m2s = $signed({1'b0, b1_c_reg.m2});
        for (int c = 0; c < 3; c++)
        begin
            b2_pv1_next[c] = 65'(b1_ipm_reg[c]) * 65'(m1s);
            b2_pv2_next[c] = 65'(b1_ipm_reg[c]) * 65'(m2s);
            b2_pm1_next[c] = 65'(b1_mpm_reg[c]) * 65'(m1s);
            b2_pm2_next[c] = 65'(b1_mpm_reg[c]) * 65'(m2s);
        end
    end

    // stage 3: apply and saturate
    always_comb
    begin
        logic signed [65:0] neg2;
        logic signed [20:0] mv1;
        logic signed [20:0] mv2;
        neg2 = '0;
        mv1  = '0;
        mv2  = '0;
        out_next.new_velocity_one = b2_c_reg.v1;
        out_next.new_velocity_two = b2_c_reg.v2;
        out_next.new_position_one = b2_c_reg.p1;
        out_next.new_position_two = b2_c_reg.p2;
        out_next.move_one         = '0;
        out_next.move_two         = '0;
        out_next.impulse_applied  = b2_imp_reg;
        out_next.moved_apart      = b2_mov_reg;
        for (int c = 0; c < 3; c++)
        begin
            if (b2_imp_reg)
            begin
                neg2 = -(66'(b2_pv2_reg[c]));
                out_next.new_velocity_one[pcr_pkg::COMP_W*c +: pcr_pkg::COMP_W] =
                    pcr_pkg::sat21(66'(pcr_pkg::comp(b2_c_reg.v1, c))
                                   + 66'(b2_pv1_reg[c] >>> 22));
                out_next.new_velocity_two[pcr_pkg::COMP_W*c +: pcr_pkg::COMP_W] =
                    pcr_pkg::sat21(66'(pcr_pkg::comp(b2_c_reg.v2, c)) + (neg2 >>> 22));
            end
            if (b2_mov_reg)
            begin
                neg2 = -(66'(b2_pm2_reg[c]));
                mv1  = pcr_pkg::sat21(66'(b2_pm1_reg[c] >>> 22));
                mv2  = pcr_pkg::sat21(neg2 >>> 22);
                out_next.move_one[pcr_pkg::COMP_W*c +: pcr_pkg::COMP_W] = mv1;
                out_next.move_two[pcr_pkg::COMP_W*c +: pcr_pkg::COMP_W] = mv2;
                out_next.new_position_one[pcr_pkg::COMP_W*c +: pcr_pkg::COMP_W] =
                    pcr_pkg::sat21(66'(pcr_pkg::comp(b2_c_reg.p1, c)) + 66'(mv1));
                out_next.new_position_two[pcr_pkg::COMP_W*c +: pcr_pkg::COMP_W] =
                    pcr_pkg::sat21(66'(pcr_pkg::comp(b2_c_reg.p2, c)) + 66'(mv2));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg  <= 1'b0;
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy0) b0_valid_reg  <= rsp_valid;
            if (rdy1) b1_valid_reg  <= b0_valid_reg;
            if (rdy2) b2_valid_reg  <= b1_valid_reg;
            if (rdy3) out_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && rsp_valid)
        begin
            b0_c_reg   <= rsp.c;
            b0_imp_reg <= rsp.imp_en;
            b0_mov_reg <= rsp.mov_en;
            b0_pn_reg  <= b0_pn_next;
            b0_qn_reg  <= b0_qn_next;
        end
        if (rdy1 && b0_valid_reg)
        begin
            b1_c_reg   <= b0_c_reg;
            b1_imp_reg <= b0_imp_reg;
            b1_mov_reg <= b0_mov_reg;
            b1_ipm_reg <= b1_ipm_next;
            b1_mpm_reg <= b1_mpm_next;
        end
        if (rdy2 && b1_valid_reg)
        begin
            b2_c_reg   <= b1_c_reg;
            b2_imp_reg <= b1_imp_reg;
            b2_mov_reg <= b1_mov_reg;
            b2_pv1_reg <= b2_pv1_next;
            b2_pv2_reg <= b2_pv2_next;
            b2_pm1_reg <= b2_pm1_next;
            b2_pm2_reg <= b2_pm2_next;
        end
        if (rdy3 && b2_valid_reg)
            out_reg <= out_next;
    end

    `PCR_ASSERT_SAME(a_no_move_when_idle, clk, rst_n,
        out_valid_reg && !out_reg.moved_apart,
        out_reg.move_one == '0 && out_reg.move_two == '0)

endmodule

// ===== hw/rtl/particle_contact_resolver_top.sv =====
// Channel   Dir  Payload                         Handshake
// item      in   pcr_pkg::item_t                 item_valid / item_ready
// result    out  pcr_pkg::result_t               result_valid / result_ready
// cfg       in   cfg_index (2b), cfg_data (32b)  cfg_valid / cfg_ready
//
// One contact per cycle sustained while result_ready stays high; 6 front-end stages,
// 33 divider stages (overflow check plus one quotient bit per stage), 4 back-end.
// The divider's bit-per-stage chain sets the depth.
// Reset clears all valid bits and loads the register defaults; no sweep.
// Every stage holds under stall and a bubble is filled as soon as it opens.
// cfg_ready is always high.
`include "particle_contact_resolver_top_assert.svh"

module particle_contact_resolver_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  pcr_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output pcr_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [pcr_pkg::RESTITUTION_W-1:0] restitution_reg;
    logic [pcr_pkg::DELTA_TIME_W-1:0]  delta_time_reg;

    logic              req_valid, req_ready;
    pcr_pkg::div_req_t req;
    logic              rsp_valid, rsp_ready;
    pcr_pkg::div_rsp_t rsp;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restitution_reg <= pcr_pkg::RESTITUTION_RESET;
            delta_time_reg  <= pcr_pkg::DELTA_TIME_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == pcr_pkg::CFG_RESTITUTION)
                restitution_reg <= cfg_data[pcr_pkg::RESTITUTION_W-1:0];
            if (cfg_index == pcr_pkg::CFG_DELTA_TIME)
                delta_time_reg <= cfg_data[pcr_pkg::DELTA_TIME_W-1:0];
        end
    end

    pcr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .restitution (restitution_reg),
        .delta_time  (delta_time_reg),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req)
    );

    pcr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    pcr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // input only backs up when a finished word is waiting at the output
    `PCR_ASSERT_SAME(a_stall_from_output, clk, rst_n,
        !item_ready, result_valid && !result_ready)

    `PCR_ASSERT_NEXT(a_cfg_restitution, clk, rst_n,
        cfg_valid && cfg_ready && cfg_index == pcr_pkg::CFG_RESTITUTION,
        restitution_reg == $past(cfg_data[pcr_pkg::RESTITUTION_W-1:0]))

endmodule
